// File: rtl/tpf_pkg.sv
package tpf_pkg;

    // Fixed widths of the ports and registers.
    localparam int EDGE_W       = 32;
    localparam int FREQ_W       = 28;
    localparam int MIN_PERIOD_W = 20;
    localparam int PPT_W        = 8;
    localparam int COUNT_W      = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 20;

    // Numerator of the fresh term before the fraction shift: 1e6 / 4.
    localparam int RATE_W          = 18;
    localparam logic [RATE_W-1:0] RATE_NUM = 18'd250000;

    localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RESET = 20'd1000;
    localparam logic [PPT_W-1:0]        PPT_RESET        = 8'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES     = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

// File: rtl/tpf_divider.sv
module tpf_divider
    import tpf_pkg::*;
#(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 32,
    parameter logic [DIVIDEND_W-1:0] DIVIDEND = '0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    // Restoring division, one quotient bit per cycle. The quotient register
    // starts out holding the dividend and shifts it out from the top while
    // the quotient bits enter at the bottom.
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_div, n_div;

    logic [DIVISOR_W:0]    w_rem_shift;
    logic [DIVISOR_W:0]    w_rem_sub;
    logic                  w_fits;

    assign w_rem_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_rem_sub   = w_rem_shift - {1'b0, r_div};
    assign w_fits      = (w_rem_shift >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_rem  = '0;
            n_quo  = DIVIDEND;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fits ? w_rem_sub[DIVISOR_W-1:0] : w_rem_shift[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], w_fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/tachometer_period_to_frequency_core.sv
// Sequence: after the input handshake an accepted edge runs through DIFF, ABS, DIV, UPDATE and
// DONE; an edge rejected as a glitch goes from ABS straight to DONE.
// Flow: one edge at a time; the next edge is taken in the cycle after the previous result
// is loaded into the output register. Most of the work of an accepted edge is the bit-serial
// divider, which makes one quotient bit per clock.
// Reset: synchronous, active low; clears state, estimate, counter, indicator and valids.
module tachometer_period_to_frequency_core
    import tpf_pkg::*;
#(
    parameter int TIME_BITS     = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input word: one sensor edge.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [EDGE_W-1:0]     i_edge_time_us,
    // Output word: one result per edge.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [FREQ_W-1:0]     o_freq_q8,
    output logic                  o_accepted,
    output logic                  o_indicator
);

    // The fresh term is (250000 << FRACTION_BITS) / period. Its dividend is a
    // constant, so the divider only needs the period as a run-time operand.
    localparam int DIV_W = RATE_W + FRACTION_BITS;
    localparam logic [DIV_W-1:0] DIVIDEND = {RATE_NUM, {FRACTION_BITS{1'b0}}};
    localparam int SUM_W = ((DIV_W > FREQ_W) ? DIV_W : FREQ_W) + 1;

    // Configuration registers.
    logic [MIN_PERIOD_W-1:0] r_min_period;
    logic [PPT_W-1:0]        r_ppt;

    // Architectural state.
    logic [TIME_BITS-1:0]    r_last, n_last;
    logic [FREQ_W-1:0]       r_est, n_est;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic                    r_ind, n_ind;

    // Working registers of the current edge.
    t_state                  r_state, n_state;
    logic [TIME_BITS-1:0]    r_now;
    logic [TIME_BITS-1:0]    r_diff;
    logic [FREQ_W-1:0]       r_decayed;
    logic                    r_acc, n_acc;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic [FREQ_W-1:0]       r_out_freq;
    logic                    r_out_acc;
    logic                    r_out_ind;

    // Sequencer outputs.
    logic                    w_in_ready;
    logic                    w_div_start;
    logic                    w_load_out;
    logic                    w_update;

    // Datapath signals.
    logic [TIME_BITS+EDGE_W-1:0] w_now_ext;
    logic [TIME_BITS-1:0]    w_period;
    logic                    w_pass;
    logic [FREQ_W+1:0]       w_triple;
    logic                    w_div_done;
    logic [DIV_W-1:0]        w_quotient;
    logic [SUM_W-1:0]        w_sum;
    logic [FREQ_W-1:0]       w_sum_sat;
    logic [COUNT_W-1:0]      w_count_inc;
    logic                    w_turn;

    // Only the low TIME_BITS bits of the stamp take part; wider timers see
    // the stamp zero-extended.
    assign w_now_ext = {{TIME_BITS{1'b0}}, i_edge_time_us};

    // Absolute two's complement difference. The most negative difference
    // negates to itself, which read unsigned is the right period.
    assign w_period = r_diff[TIME_BITS-1] ? (~r_diff + TIME_BITS'(1)) : r_diff;
    assign w_pass   = ({{MIN_PERIOD_W{1'b0}}, w_period} > {{TIME_BITS{1'b0}}, r_min_period});

    // Decay to three quarters with truncation: (3 * est) >> 2.
    assign w_triple = {2'b00, r_est} + {1'b0, r_est, 1'b0};

    // New estimate, saturated to the full output range.
    assign w_sum     = SUM_W'({r_decayed}) + SUM_W'(w_quotient);
    assign w_sum_sat = (w_sum[SUM_W-1:FREQ_W] != '0) ? {FREQ_W{1'b1}} : w_sum[FREQ_W-1:0];

    // Revolution indicator: toggle once twice the edge count reaches the
    // pulses-per-turn setting, and start counting again.
    assign w_count_inc = r_count + COUNT_W'(1);
    assign w_turn      = ({w_count_inc, 1'b0} >= {1'b0, r_ppt});

    // The divider latches its divisor on the start cycle, so it takes the
    // period straight from the absolute-value logic.
    tpf_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (TIME_BITS),
        .DIVIDEND   (DIVIDEND)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (w_period),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = ST_ABS;
            end
            ST_ABS: begin
                n_state = w_pass ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        w_update    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_ABS: begin
                w_div_start = w_pass;
            end
            ST_UPDATE: begin
                w_update = 1'b1;
            end
            ST_DONE: begin
                w_load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // State updates of an edge: the accept flag for every edge, the rest for an accepted one.
    always_comb begin
        n_last  = r_last;
        n_est   = r_est;
        n_count = r_count;
        n_ind   = r_ind;
        n_acc   = r_acc;
        if (r_state == ST_ABS) begin
            n_acc = w_pass;
        end
        if (w_update) begin
            n_last = r_now;
            n_est  = w_sum_sat;
            if (w_turn) begin
                n_count = '0;
                n_ind   = ~r_ind;
            end else begin
                n_count = w_count_inc;
            end
        end
    end

    // The output register frees as soon as its word is taken, so a result
    // can wait there while the next edge is already accepted.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_min_period <= MIN_PERIOD_RESET;
            r_ppt        <= PPT_RESET;
            r_last       <= '0;
            r_est        <= '0;
            r_count      <= '0;
            r_ind        <= 1'b0;
            r_acc        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_est       <= n_est;
            r_count     <= n_count;
            r_ind       <= n_ind;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_PERIOD: r_min_period <= i_cfg_data[MIN_PERIOD_W-1:0];
                    CFG_PULSES:     r_ppt        <= i_cfg_data[PPT_W-1:0];
                    default:        r_ppt        <= r_ppt;
                endcase
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_now <= w_now_ext[TIME_BITS-1:0];
        end
        if (r_state == ST_DIFF) begin
            r_diff <= r_now - r_last;
        end
        if (r_state == ST_ABS) begin
            r_decayed <= w_triple[FREQ_W+1:2];
        end
        if (w_load_out) begin
            r_out_freq <= r_est;
            r_out_acc  <= r_acc;
            r_out_ind  <= r_ind;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_freq_q8   = r_out_freq;
    assign o_accepted  = r_out_acc;
    assign o_indicator = r_out_ind;

endmodule

// File: rtl/tpf_checker.sv
module tpf_checker
    import tpf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [FREQ_W-1:0] o_freq_q8,
    input logic              o_accepted,
    input logic              o_indicator
);

    // Last delivered result, to check that a rejected edge leaves the
    // estimate and indicator as they were.
    logic              r_have;
    logic [FREQ_W-1:0] r_last_freq;
    logic              r_last_ind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            r_last_freq <= o_freq_q8;
            r_last_ind  <= o_indicator;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("outputs not cleared by reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_freq_q8)))
        else $error("stalled result word changed or dropped");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_accepted && r_have)
            |-> (o_freq_q8 == r_last_freq && o_indicator == r_last_ind))
        else $error("rejected edge changed the estimate or indicator");

endmodule

bind tachometer_period_to_frequency_core tpf_checker u_tpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_freq_q8   (o_freq_q8),
    .o_accepted  (o_accepted),
    .o_indicator (o_indicator)
);
